@@ sv/dsl_pkg.sv @@
// Shared types, constants and helper functions of the string lookup core.
package dsl_pkg;

  localparam int PW = 22;
  localparam logic [PW-1:0] POS_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    K_GRAPH = 2'd0,
    K_KEY   = 2'd1,
    K_LAST  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [16:0] addr;
    logic [7:0]  data;
  } item_t;

  localparam logic [1:0] ST_MISS  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam logic [7:0] OFS3_TAG  = 8'h60;
  localparam logic [7:0] OFS2_TAG  = 8'h40;
  localparam logic [7:0] MB_MARK   = 8'h1F;
  localparam logic [7:0] OFS1_MASK = 8'h3F;
  localparam logic [7:0] MB_LEAD   = 8'h80;
  localparam logic [7:0] MB_FOLLOW = 8'hC0;
  localparam logic [7:0] VAL_MASK  = 8'hE0;
  localparam logic [7:0] NIB_MASK  = 8'h0F;

  function automatic logic [2:0] mb_len(input logic [7:0] c);
    logic [2:0] r;
    case (c[7:4])
      4'hC, 4'hD: r = 3'd2;
      4'hE:       r = 3'd3;
      4'hF:       r = 3'd4;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a, input logic [20:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {2'b00, b};
    return s[PW] ? POS_MAX : s[PW-1:0];
  endfunction

  function automatic logic byte_match(input logic [7:0] m, input logic [7:0] k,
                                      input logic mba, input logic first);
    logic r;
    if (mba) begin
      r = first ? ((m ^ MB_LEAD) == k) : ((m ^ MB_FOLLOW) == k);
    end else if (mb_len(k) != 3'd0) begin
      r = (m == MB_MARK);
    end else begin
      r = (m == k);
    end
    return r;
  endfunction

endpackage

@@ sv/dsl_ifs.sv @@
// Channel interfaces of the string lookup core.
interface dsl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [16:0] graph_address;
  logic [7:0]  graph_byte;
  logic [7:0]  key_byte;
  logic        key_last;
  modport source (output valid, command, graph_address, graph_byte, key_byte, key_last,
                  input ready);
  modport sink (input valid, command, graph_address, graph_byte, key_byte, key_last,
                output ready);
endinterface

interface dsl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lookup_status;
  logic [3:0] match_value;
  modport source (output valid, lookup_status, match_value, input ready);
  modport sink (input valid, lookup_status, match_value, output ready);
endinterface

interface dsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [17:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/dafsa_string_lookup_core.sv @@
// Top level of the DAFSA string lookup core.
// Throughput: graph writes and non-final key bytes retire one per cycle while the walker is
// idle with no result pending. Lookup: a start state, then per list entry tried the list, B0,
// B1, B2 and node states, node repeating per further node byte, all on the single graph store
// read port; the result is valid in the cycle after the walk ends. An over-long key answers
// from idle. Reset: synchronous active-low rst_n clears control, graph_length and key count.
module dafsa_string_lookup_core
  import dsl_pkg::*;
#(
  parameter int GRAPH_BYTES   = 131072,
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  dsl_in_if.sink     in_ch,
  dsl_cfg_if.sink    cfg_ch,
  dsl_out_if.source  out_ch
);

  logic  q_valid, q_ready;
  item_t q_item;

  dsl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  dsl_back #(
    .GRAPH_BYTES   (GRAPH_BYTES),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

@@ sv/dsl_front.sv @@
// Input classifier and item queue of the string lookup core.
module dsl_front
  import dsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dsl_in_if.sink     in_ch,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_ready
);

  localparam int DEPTH = 4;

  item_t      mem_r [DEPTH];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push, pop;

  always_comb begin
    cls.addr = in_ch.graph_address;
    if (!in_ch.command) begin
      cls.kind = K_GRAPH;
      cls.data = in_ch.graph_byte;
    end else begin
      cls.kind = in_ch.key_last ? K_LAST : K_KEY;
      cls.data = in_ch.key_byte;
    end
  end

  assign in_ch.ready = (cnt_r != 3'(DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 3'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + 2'd1 : wp_r;
    rp_nxt = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH)) else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 3'd1) else $error("queue count lost a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[1:0]) else $error("queue pointers disagree with count");
`endif

endmodule

@@ sv/dsl_back.sv @@
// Graph store, key buffer and graph walker of the string lookup core.
module dsl_back
  import dsl_pkg::*;
#(
  parameter int GRAPH_BYTES   = 131072,
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_ready,
  dsl_cfg_if.sink    cfg_ch,
  dsl_out_if.source  out_ch
);

  localparam int AW = $clog2(GRAPH_BYTES);
  localparam int KA = $clog2(MAX_KEY_BYTES);
  localparam int KW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [PW-1:0] GEND_MAX = PW'(GRAPH_BYTES);
  localparam logic [KW-1:0] KMAX = KW'(MAX_KEY_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_LIST  = 7'b0000100,
    S_B0    = 7'b0001000,
    S_B1    = 7'b0010000,
    S_B2    = 7'b0100000,
    S_NODE  = 7'b1000000
  } state_t;

  logic [7:0] gmem [GRAPH_BYTES];
  logic [7:0] kmem [MAX_KEY_BYTES];

  state_t        state_r, state_nxt;
  logic [KW-1:0] kcnt_r, kcnt_nxt, ki_r, ki_nxt, mbb_r, mbb_nxt;
  logic          ovf_r, ovf_nxt, mba_r, mba_nxt, cons_r, cons_nxt;
  logic [2:0]    mblen_r, mblen_nxt;
  logic [PW-1:0] lp_r, lp_nxt, np_r, np_nxt, gend_r, gend_nxt, rd_addr;
  logic [7:0]    b0_r, b0_nxt, b1_r, b1_nxt, gdata_r, kdata_r;
  logic [17:0]   glen_r;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [3:0]    out_value_r, out_value_nxt;
  logic          gwe, kwe, take, nb_ok, lbl_end, first_mb;
  logic [PW-1:0] np_adv, np_new, waddr_ext;
  logic [KW-1:0] ki_adv, mbb_adv, ki_p1;
  logic          mba_adv;
  logic [2:0]    mblen_adv;
  logic [20:0]   add;
  logic [PW:0]   lp_p2;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.lookup_status = out_status_r;
  assign out_ch.match_value = out_value_r;

  assign q_ready = (state_r == S_IDLE) && !out_valid_r;
  assign take = q_valid && q_ready;
  assign waddr_ext = {{(PW - 17){1'b0}}, q_item.addr};

  assign nb_ok = np_r < gend_r;
  assign lbl_end = nb_ok && gdata_r[7];
  assign first_mb = (mbb_r == ki_r);
  assign ki_p1 = ki_r + 1'b1;
  assign lp_p2 = {1'b0, lp_r} + (PW + 1)'(2);

  always_comb begin
    np_adv = sat_add(np_r, 21'd1);
    ki_adv = ki_r;
    mbb_adv = mbb_r;
    mba_adv = mba_r;
    mblen_adv = mblen_r;
    if (mba_r) begin
      ki_adv = ki_p1;
      if ((ki_p1 - mbb_r) == KW'(mblen_r)) begin
        mba_adv = 1'b0;
      end
    end else if (mb_len(kdata_r) != 3'd0) begin
      mbb_adv = ki_r;
      mba_adv = 1'b1;
      mblen_adv = mb_len(kdata_r);
    end else begin
      ki_adv = ki_p1;
    end
  end

  always_comb begin
    case (b0_r & OFS3_TAG)
      OFS3_TAG: add = {b0_r[4:0], b1_r, gdata_r};
      OFS2_TAG: add = {8'd0, b0_r[4:0], b1_r};
      default:  add = {15'd0, b0_r[5:0] & OFS1_MASK[5:0]};
    endcase
    np_new = sat_add(np_r, add);
  end

  always_comb begin
    state_nxt = state_r;
    kcnt_nxt = kcnt_r;
    ovf_nxt = ovf_r;
    ki_nxt = ki_r;
    mbb_nxt = mbb_r;
    mba_nxt = mba_r;
    mblen_nxt = mblen_r;
    cons_nxt = cons_r;
    lp_nxt = lp_r;
    np_nxt = np_r;
    gend_nxt = gend_r;
    b0_nxt = b0_r;
    b1_nxt = b1_r;
    rd_addr = np_r;
    gwe = 1'b0;
    kwe = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt = out_value_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (q_item.kind == K_GRAPH) begin
            gwe = waddr_ext < GEND_MAX;
          end else begin
            if (kcnt_r < KMAX) begin
              kwe = 1'b1;
              kcnt_nxt = kcnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (q_item.kind == K_LAST) begin
              if (ovf_nxt) begin
                out_valid_nxt = 1'b1;
                out_status_nxt = ST_LONG;
                out_value_nxt = '0;
                kcnt_nxt = '0;
                ovf_nxt = 1'b0;
              end else begin
                gend_nxt = (PW'(glen_r) < GEND_MAX) ? PW'(glen_r) : GEND_MAX;
                lp_nxt = '0;
                np_nxt = '0;
                ki_nxt = '0;
                mbb_nxt = '0;
                mba_nxt = 1'b0;
                state_nxt = S_START;
              end
            end
          end
        end
      end
      S_START: begin
        state_nxt = S_LIST;
      end
      S_LIST: begin
        rd_addr = lp_r;
        if (lp_p2 >= {1'b0, gend_r}) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_MISS;
          out_value_nxt = '0;
          kcnt_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_B0;
        end
      end
      S_B0: begin
        b0_nxt = gdata_r;
        rd_addr = lp_r + 1'b1;
        state_nxt = S_B1;
      end
      S_B1: begin
        b1_nxt = gdata_r;
        rd_addr = lp_p2[PW-1:0];
        state_nxt = S_B2;
      end
      S_B2: begin
        np_nxt = np_new;
        rd_addr = np_new;
        lp_nxt = b0_r[7] ? gend_r :
                 ((b0_r & OFS3_TAG) == OFS3_TAG) ? lp_p2[PW-1:0] + 1'b1 :
                 ((b0_r & OFS3_TAG) == OFS2_TAG) ? lp_r + 1'b1 + 1'b1 : lp_r + 1'b1;
        cons_nxt = 1'b0;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        if (ki_r != kcnt_r && !lbl_end) begin
          if (!(nb_ok && byte_match(gdata_r, kdata_r, mba_r, first_mb))) begin
            if (cons_r) begin
              out_valid_nxt = 1'b1;
              out_status_nxt = ST_MISS;
              out_value_nxt = '0;
              kcnt_nxt = '0;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_LIST;
            end
          end else begin
            cons_nxt = 1'b1;
            np_nxt = np_adv;
            rd_addr = np_adv;
            ki_nxt = ki_adv;
            mbb_nxt = mbb_adv;
            mba_nxt = mba_adv;
            mblen_nxt = mblen_adv;
          end
        end else if (ki_r == kcnt_r) begin
          if (nb_ok && !mba_r && ((gdata_r & VAL_MASK) == MB_LEAD)) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = ST_FOUND;
            out_value_nxt = gdata_r[3:0] & NIB_MASK[3:0];
            kcnt_nxt = '0;
            state_nxt = S_IDLE;
          end else if (cons_r) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = ST_MISS;
            out_value_nxt = '0;
            kcnt_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LIST;
          end
        end else if (!(nb_ok && byte_match(gdata_r ^ MB_LEAD, kdata_r, mba_r, first_mb))) begin
          if (cons_r) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = ST_MISS;
            out_value_nxt = '0;
            kcnt_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LIST;
          end
        end else begin
          np_nxt = np_adv;
          lp_nxt = np_adv;
          ki_nxt = ki_adv;
          mbb_nxt = mbb_adv;
          mba_nxt = mba_adv;
          mblen_nxt = mblen_adv;
          state_nxt = S_LIST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      gmem[waddr_ext[AW-1:0]] <= q_item.data;
    end
    gdata_r <= gmem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[kcnt_r[KA-1:0]] <= q_item.data;
    end
    kdata_r <= kmem[ki_nxt[KA-1:0]];
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    lp_r <= lp_nxt;
    np_r <= np_nxt;
    gend_r <= gend_nxt;
    ki_r <= ki_nxt;
    mbb_r <= mbb_nxt;
    mblen_r <= mblen_nxt;
    out_status_r <= out_status_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kcnt_r <= '0;
      ovf_r <= 1'b0;
      mba_r <= 1'b0;
      cons_r <= 1'b0;
      glen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kcnt_r <= kcnt_nxt;
      ovf_r <= ovf_nxt;
      mba_r <= mba_nxt;
      cons_r <= cons_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        glen_r <= cfg_ch.data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_kcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kcnt_r <= KMAX) else $error("key count beyond buffer");
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_MISS || out_status_r == ST_FOUND ||
                     out_status_r == ST_LONG)) else $error("illegal status");
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_FOUND) |-> out_value_r == 4'd0)
    else $error("value set on a miss");
  a_walk_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r) else $error("walk with a pending result");
`endif

endmodule
